FILE: hdl/sbr_pkg.sv
// Shared constants and control types of the stream byte reassembler.
// No dependencies; every other file of the block but sbr_ram imports this package.
package sbr_pkg;

	localparam int CAPACITY = 64;                      // ring entries, 2..64
	localparam int SLOT_W   = $clog2(CAPACITY);        // ring index width
	localparam int CNT_W    = $clog2(CAPACITY + 1);    // held byte count width
	localparam int IDX_W    = 32;                      // stream index width
	localparam int POS_W    = IDX_W + 1;               // end index width
	localparam int BYTE_W   = 8;
	localparam int BUF_W    = 7;                       // downstream fill width
	localparam int PEND_W   = 7;                       // pending count width

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic take;      // input transaction: latch item, window and end index
		logic store;     // write the kept byte into the ring
		logic drain;     // pop the byte at next_needed and read it
		logic status;    // load a status-only result
		logic load;      // load the byte read by the previous drain
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic out_free;  // result register empty or emptied this cycle
		logic drain_ok;  // data item and the byte at next_needed is present
		logic more;      // byte at the (advanced) next_needed is present
	} dp_sts_t;

endpackage

FILE: hdl/sbr_seg_if.sv
// Segment byte channel: valid/ready handshake with one segment byte per transaction.
// Depends on sbr_pkg for field widths.
interface sbr_seg_if;
	import sbr_pkg::*;

	logic                valid;
	logic                ready;
	logic [IDX_W-1:0]    byte_index;
	logic [BYTE_W-1:0]   data_byte;
	logic                first_of_segment;
	logic                last_of_segment;
	logic                eof_flag;
	logic                no_data;
	logic [BUF_W-1:0]    stream_buffered;

	modport source (
		output valid, byte_index, data_byte, first_of_segment, last_of_segment,
		       eof_flag, no_data, stream_buffered,
		input  ready
	);
	modport sink (
		input  valid, byte_index, data_byte, first_of_segment, last_of_segment,
		       eof_flag, no_data, stream_buffered,
		output ready
	);

endinterface

FILE: hdl/sbr_stream_if.sv
// Assembled stream channel: valid/ready handshake with one result per transaction.
// Depends on sbr_pkg for field widths.
interface sbr_stream_if;
	import sbr_pkg::*;

	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   out_byte;
	logic                byte_valid;
	logic                run_last;
	logic [PEND_W-1:0]   pending_count;
	logic                stream_ended;

	modport source (
		output valid, out_byte, byte_valid, run_last, pending_count, stream_ended,
		input  ready
	);
	modport sink (
		input  valid, out_byte, byte_valid, run_last, pending_count, stream_ended,
		output ready
	);

endinterface

FILE: hdl/stream_byte_reassembler.sv
// Stream byte reassembler: out-of-order segment bytes in, in-order stream bytes out.
// Each segment transaction is followed by a store into the ring and a check of next_needed;
// the check, which waits while the result register is occupied, either loads a status-only
// result or drains a byte (ring read, then result load) and repeats while bytes are present.
// Reset: valid bits, counters, window and end tracking clear at once; ring contents
// are undefined until written and need no clearing pass.
module stream_byte_reassembler (
	input  logic   clk,
	input  logic   arst_n,
	sbr_seg_if.sink      segment,
	sbr_stream_if.source stream
);
	import sbr_pkg::*;

	ctrl_cmd_t cmd;
	dp_sts_t   sts;

	sbr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.seg_valid (segment.valid),
		.seg_ready (segment.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbr_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.byte_index       (segment.byte_index),
		.data_byte        (segment.data_byte),
		.first_of_segment (segment.first_of_segment),
		.last_of_segment  (segment.last_of_segment),
		.eof_flag         (segment.eof_flag),
		.no_data          (segment.no_data),
		.stream_buffered  (segment.stream_buffered),
		.out_valid        (stream.valid),
		.out_ready        (stream.ready),
		.out_byte         (stream.out_byte),
		.byte_valid       (stream.byte_valid),
		.run_last         (stream.run_last),
		.pending_count    (stream.pending_count),
		.stream_ended     (stream.stream_ended)
	);

endmodule

FILE: hdl/sbr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sbr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/sbr_ctrl.sv
// Controller of the reassembler: sequences take, store, drain and result loading.
// Depends on sbr_pkg for the command and status structs.
module sbr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                seg_valid,
	output logic                seg_ready,
	input  sbr_pkg::dp_sts_t    sts,
	output sbr_pkg::ctrl_cmd_t  cmd
);
	import sbr_pkg::*;

	typedef enum logic [1:0] {
		IDLE,
		STORE,
		CHECK,
		LOAD
	} state_t;

	state_t state_q;
	logic   ready_q;

	assign seg_ready = ready_q;

	always_comb begin
		cmd        = '0;
		cmd.take   = ready_q && seg_valid;
		cmd.store  = (state_q == STORE);
		cmd.drain  = (state_q == CHECK) && sts.out_free && sts.drain_ok;
		cmd.status = (state_q == CHECK) && sts.out_free && !sts.drain_ok;
		cmd.load   = (state_q == LOAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				IDLE: begin
					if (cmd.take) begin
						state_q <= STORE;
						ready_q <= 1'b0;
					end
				end
				STORE: begin
					state_q <= CHECK;
				end
				CHECK: begin
					// hold until the result register can take the next result
					if (cmd.drain) begin
						state_q <= LOAD;
					end else if (cmd.status) begin
						state_q <= IDLE;
						ready_q <= 1'b1;
					end
				end
				LOAD: begin
					if (sts.more) begin
						state_q <= CHECK;
					end else begin
						state_q <= IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.take, cmd.store, cmd.drain, cmd.status, cmd.load}))
		else $error("controller issued more than one command");

	a_result_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.drain || cmd.status) |-> sts.out_free)
		else $error("result produced while the result register is occupied");

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> !ready_q)
		else $error("ready stayed high after a segment transaction");

endmodule

FILE: hdl/sbr_dp.sv
// Datapath of the reassembler: byte ring, valid bits, window and end tracking,
// result register. Depends on sbr_pkg and sbr_ram.
module sbr_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sbr_pkg::ctrl_cmd_t          cmd,
	output sbr_pkg::dp_sts_t            sts,
	input  logic [sbr_pkg::IDX_W-1:0]   byte_index,
	input  logic [sbr_pkg::BYTE_W-1:0]  data_byte,
	input  logic                        first_of_segment,
	input  logic                        last_of_segment,
	input  logic                        eof_flag,
	input  logic                        no_data,
	input  logic [sbr_pkg::BUF_W-1:0]   stream_buffered,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [sbr_pkg::BYTE_W-1:0]  out_byte,
	output logic                        byte_valid,
	output logic                        run_last,
	output logic [sbr_pkg::PEND_W-1:0]  pending_count,
	output logic                        stream_ended
);
	import sbr_pkg::*;

	// Stream state
	logic [CAPACITY-1:0] present_q;
	logic [IDX_W-1:0]    next_q;
	logic [SLOT_W-1:0]   next_slot_q;
	logic [IDX_W-1:0]    window_q;
	logic                end_known_q;
	logic [POS_W-1:0]    end_pos_q;
	logic [CNT_W-1:0]    held_q;
	logic                ended_q;

	// Latched item
	logic [IDX_W-1:0]    idx_q;
	logic [BYTE_W-1:0]   data_q;
	logic                nodata_q;
	logic                below_q;
	logic [SLOT_W-1:0]   diff_q;

	// Result register
	logic                ov_q;
	logic [BYTE_W-1:0]   ob_q;
	logic                obv_q;
	logic                olast_q;
	logic [PEND_W-1:0]   opend_q;
	logic                oend_q;

	logic [BUF_W-1:0]    win;
	logic [POS_W-1:0]    lim;
	logic [IDX_W-1:0]    lim_clamped;
	logic                has_end;
	logic [POS_W-1:0]    end_cand;
	logic [POS_W-1:0]    diff_full;
	logic                keep;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   wslot;
	logic [SLOT_W-1:0]   next_slot_inc;
	logic [IDX_W-1:0]    next_inc;
	logic                ended_drain;
	logic                ended_status;
	logic [BYTE_W-1:0]   ram_rdata;

	// Window of the segment: capacity minus downstream fill, floored at zero
	assign win         = (stream_buffered < BUF_W'(CAPACITY)) ?
	                     BUF_W'(CAPACITY) - stream_buffered : '0;
	assign lim         = {1'b0, next_q} + POS_W'(win);
	assign lim_clamped = lim[IDX_W] ? '1 : lim[IDX_W-1:0];

	assign has_end  = no_data ? eof_flag : (last_of_segment && eof_flag);
	assign end_cand = no_data ? {1'b0, byte_index} : {1'b0, byte_index} + POS_W'(1);
	assign diff_full = {1'b0, byte_index} - {1'b0, next_q};

	// Kept bytes sit less than CAPACITY above next_needed; wrap the slot once
	assign keep     = !nodata_q && !below_q && (idx_q < window_q);
	assign slot_sum = {1'b0, next_slot_q} + {1'b0, diff_q};
	assign wslot    = (slot_sum >= (SLOT_W+1)'(CAPACITY)) ?
	                  SLOT_W'(slot_sum - (SLOT_W+1)'(CAPACITY)) : slot_sum[SLOT_W-1:0];

	assign next_slot_inc = (next_slot_q == SLOT_W'(CAPACITY - 1)) ? '0 :
	                       next_slot_q + SLOT_W'(1);
	assign next_inc      = next_q + IDX_W'(1);
	assign ended_drain   = ended_q || (end_known_q && ({1'b0, next_inc} == end_pos_q));
	assign ended_status  = ended_q || (end_known_q && ({1'b0, next_q} == end_pos_q));

	assign sts.out_free = !ov_q || out_ready;
	assign sts.drain_ok = !nodata_q && present_q[next_slot_q];
	assign sts.more     = present_q[next_slot_q];

	sbr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (CAPACITY)
	) u_ring (
		.clk   (clk),
		.we    (cmd.store && keep),
		.waddr (wslot),
		.wdata (data_q),
		.re    (cmd.drain),
		.raddr (next_slot_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			idx_q    <= byte_index;
			data_q   <= data_byte;
			nodata_q <= no_data;
			below_q  <= diff_full[IDX_W];
			diff_q   <= diff_full[SLOT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			next_q      <= '0;
			next_slot_q <= '0;
			window_q    <= '0;
			end_known_q <= 1'b0;
			end_pos_q   <= '0;
			held_q      <= '0;
			ended_q     <= 1'b0;
		end else begin
			if (cmd.take) begin
				if (first_of_segment && !no_data) begin
					window_q <= lim_clamped;
				end
				// keep the smallest end index seen
				if (has_end && (!end_known_q || end_cand < end_pos_q)) begin
					end_pos_q <= end_cand;
				end
				if (has_end) begin
					end_known_q <= 1'b1;
				end
			end
			if (cmd.store && keep) begin
				present_q[wslot] <= 1'b1;
				if (!present_q[wslot]) begin
					held_q <= held_q + CNT_W'(1);
				end
			end
			if (cmd.drain) begin
				present_q[next_slot_q] <= 1'b0;
				held_q      <= held_q - CNT_W'(1);
				next_q      <= next_inc;
				next_slot_q <= next_slot_inc;
				ended_q     <= ended_drain;
			end
			if (cmd.status) begin
				ended_q <= ended_status;
			end
		end
	end

	// Result register: frees the controller while a result waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.status || cmd.load) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.status) begin
			ob_q    <= '0;
			obv_q   <= 1'b0;
			olast_q <= 1'b1;
			opend_q <= PEND_W'(held_q);
			oend_q  <= ended_status;
		end else if (cmd.load) begin
			ob_q    <= ram_rdata;
			obv_q   <= 1'b1;
			olast_q <= !present_q[next_slot_q];
			opend_q <= PEND_W'(held_q);
			oend_q  <= ended_q;
		end
	end

	assign out_valid     = ov_q;
	assign out_byte      = ob_q;
	assign byte_valid    = obv_q;
	assign run_last      = olast_q;
	assign pending_count = opend_q;
	assign stream_ended  = oend_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CNT_W'(CAPACITY))
		else $error("held byte count exceeds capacity");

	a_drain_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.drain |=> (next_q == $past(next_q) + IDX_W'(1)) && (held_q == $past(held_q) - CNT_W'(1)))
		else $error("drain did not advance next_needed and held count together");

	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !ov_q)
		else $error("drained byte loaded over a pending result");

endmodule
